[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sct_pkg.sv]
// Constants and types of the sleep countdown table.
package sct_pkg;

    localparam int MAX_SLEEPERS = 16;
    localparam int TICK_WIDTH   = 16;
    localparam int ID_W         = 8;

    typedef struct packed {
        logic                  valid;
        logic                  expired;
        logic [ID_W-1:0]       id;
        logic [TICK_WIDTH-1:0] rem;
    } t_entry;

    // signals rippling along the row, newest cell first
    typedef struct packed {
        logic            found;   // an expired entry sits at or before this point
        logic            rest;    // a further expired entry behind the selected one
        logic [ID_W-1:0] id;      // id of the selected entry
    } t_ripple;

    typedef struct packed {
        logic insert;   // shift towards the tail, new word into cell 0
        logic tick;     // count down, mark expiries
        logic remove;   // drop the selected entry, close the gap
    } t_chain_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_WAKE
    } t_state;

endpackage

[rtl/sct_cell.sv]
// One slot of the sleeper row: holds an entry and passes it to its neighbours.
module sct_cell import sct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctrl i_ctrl,
    input  t_entry      i_left,
    input  t_entry      i_right,
    input  t_ripple     i_rip,
    output t_ripple     o_rip,
    output t_entry      o_entry
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_found;
    logic   w_sel;

    assign w_found = i_rip.found | r_entry.expired;
    assign w_sel   = r_entry.expired & ~i_rip.found;

    assign o_rip.found = w_found;
    assign o_rip.rest  = i_rip.rest | (r_entry.expired & i_rip.found);
    assign o_rip.id    = i_rip.id | (w_sel ? r_entry.id : '0);
    assign o_entry     = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            n_entry = i_left;
        end else if (i_ctrl.tick) begin
            n_entry.expired = r_entry.valid & (r_entry.rem <= TICK_WIDTH'(1));
            n_entry.rem     = r_entry.rem - TICK_WIDTH'(1);
        end else if (i_ctrl.remove && w_found) begin
            // selected cell and everything older pull from the right
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid   <= 1'b0;
            r_entry.expired <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

[rtl/sleep_countdown_table_unit.sv]
// Top level of the sleep countdown table: row of cells plus wake sequencer.
// Sleep request: one result, strobed the cycle after start; busy stays low.
// Tick: the row counts down, then ST_WAKE (busy) registers one result per
// cycle, one per entry woken or else one bare one, newest sleeper first.
// Throughput: one request per cycle while not busy; ticks hold off words.
// Synchronous active-low reset empties the table; results cannot be stalled.
module sleep_countdown_table_unit import sct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [7:0]  i_thread_id,
    input  logic [15:0] i_ticks,
    input  logic        i_machine_idle,
    output logic        o_strobe,
    output logic        o_woken_valid,
    output logic [7:0]  o_woken_thread,
    output logic        o_yield_request,
    output logic        o_request_rejected,
    output logic        o_last
);

    t_state      r_state;
    t_state      n_state;
    t_chain_ctrl w_ctrl;
    t_entry      w_entry [MAX_SLEEPERS];
    t_ripple     w_rip   [MAX_SLEEPERS+1];
    t_entry      w_new;
    t_entry      w_empty;
    logic        w_accept;
    logic        w_full;
    logic        w_any;
    logic        r_yield;

    logic            r_strobe, n_strobe;
    logic            r_woken_valid, n_woken_valid;
    logic [ID_W-1:0] r_woken_thread, n_woken_thread;
    logic            r_yield_req, n_yield_req;
    logic            r_rejected, n_rejected;
    logic            r_last, n_last;

    assign busy     = (r_state == ST_WAKE);
    assign w_accept = start & ~busy;
    assign w_full   = w_entry[MAX_SLEEPERS-1].valid;
    assign w_any    = w_rip[MAX_SLEEPERS].found;

    assign w_new.valid   = 1'b1;
    assign w_new.expired = 1'b0;
    assign w_new.id      = i_thread_id;
    assign w_new.rem     = TICK_WIDTH'(i_ticks);
    assign w_empty       = '0;
    assign w_rip[0]      = '0;

    for (genvar g = 0; g < MAX_SLEEPERS; g++) begin : g_cell
        t_entry w_l;
        t_entry w_r;
        if (g == 0) begin : g_head
            assign w_l = w_new;
        end else begin : g_mid
            assign w_l = w_entry[g-1];
        end
        if (g == MAX_SLEEPERS-1) begin : g_tail
            assign w_r = w_empty;
        end else begin : g_body
            assign w_r = w_entry[g+1];
        end
        sct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_left  (w_l),
            .i_right (w_r),
            .i_rip   (w_rip[g]),
            .o_rip   (w_rip[g+1]),
            .o_entry (w_entry[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && !i_opcode) n_state = ST_WAKE;
            end
            ST_WAKE: begin
                if (!w_any || !w_rip[MAX_SLEEPERS].rest) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and row control
    always_comb begin
        w_ctrl         = '0;
        n_strobe       = 1'b0;
        n_woken_valid  = 1'b0;
        n_woken_thread = '0;
        n_yield_req    = 1'b0;
        n_rejected     = 1'b0;
        n_last         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_opcode) begin
                    w_ctrl.insert = ~w_full;
                    n_strobe      = 1'b1;
                    n_rejected    = w_full;
                    n_last        = 1'b1;
                end else if (w_accept) begin
                    w_ctrl.tick = 1'b1;
                end
            end
            ST_WAKE: begin
                n_strobe = 1'b1;
                if (w_any) begin
                    w_ctrl.remove  = 1'b1;
                    n_woken_valid  = 1'b1;
                    n_woken_thread = w_rip[MAX_SLEEPERS].id;
                    n_last         = ~w_rip[MAX_SLEEPERS].rest;
                    n_yield_req    = ~w_rip[MAX_SLEEPERS].rest & r_yield;
                end else begin
                    n_last      = 1'b1;
                    n_yield_req = r_yield;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !i_opcode) r_yield <= ~i_machine_idle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_strobe       <= 1'b0;
            r_woken_valid  <= 1'b0;
            r_woken_thread <= '0;
            r_yield_req    <= 1'b0;
            r_rejected     <= 1'b0;
            r_last         <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_strobe       <= n_strobe;
            r_woken_valid  <= n_woken_valid;
            r_woken_thread <= n_woken_thread;
            r_yield_req    <= n_yield_req;
            r_rejected     <= n_rejected;
            r_last         <= n_last;
        end
    end

    assign o_strobe           = r_strobe;
    assign o_woken_valid      = r_woken_valid;
    assign o_woken_thread     = r_woken_thread;
    assign o_yield_request    = r_yield_req;
    assign o_request_rejected = r_rejected;
    assign o_last             = r_last;

endmodule

[rtl/sct_checker.sv]
// Port-level checks of the sleep countdown table, bound to the top level.
`include "assert_macros.svh"

module sct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_opcode,
    input logic        o_strobe,
    input logic        o_woken_valid,
    input logic        o_yield_request,
    input logic        o_request_rejected,
    input logic        o_last
);

    // a result naming no thread always closes its item
    `SCT_ASSERT_NOW(a_nowake_last, i_clk, i_rst_n, o_strobe && !o_woken_valid, o_last, "non-wake word without last")

    // yield only rides on the closing word of a tick
    `SCT_ASSERT_NOW(a_yield_last, i_clk, i_rst_n, o_yield_request, o_strobe && o_last && !o_request_rejected, "yield outside last tick word")

    // a sleep request answers in the next cycle without going busy
    `SCT_ASSERT_NEXT(a_req_answer, i_clk, i_rst_n, start && !busy && i_opcode, o_strobe && o_last && !busy && !o_woken_valid, "request not answered")

    // a tick always occupies the sequencer
    `SCT_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, start && !busy && !i_opcode, busy, "tick did not raise busy")

    // wake words of one tick come back to back
    `SCT_ASSERT_NEXT(a_wake_burst, i_clk, i_rst_n, o_strobe && !o_last, o_strobe && o_woken_valid, "gap inside wake burst")

endmodule

bind sleep_countdown_table_unit sct_checker u_sct_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the sleep countdown table: directed and random words.
module tb_top import sct_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SLEEP = 1'b1;
    localparam int   MAX_PRINTED = 30;
    localparam int   DRAIN_LIMIT = 2000;

    typedef struct {
        logic       woken_valid;
        logic [7:0] woken_thread;
        logic       yield_request;
        logic       request_rejected;
        logic       last;
    } t_wake_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode = OP_TICK;
    logic [7:0]  i_thread_id = '0;
    logic [15:0] i_ticks = '0;
    logic        i_machine_idle = 1'b0;
    logic        o_strobe;
    logic        o_woken_valid;
    logic [7:0]  o_woken_thread;
    logic        o_yield_request;
    logic        o_request_rejected;
    logic        o_last;

    // own copy of the table: slot 0 newest, valid slots packed at the front
    logic [TICK_WIDTH:0] sleep_left[MAX_SLEEPERS];
    logic [ID_W-1:0]     sleep_owner[MAX_SLEEPERS];
    int                  sleepers = 0;

    t_wake_result wake_q[$];
    int           err_count = 0;
    bit           quiet_phase = 1'b0;

    sleep_countdown_table_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_thread_id        (i_thread_id),
        .i_ticks            (i_ticks),
        .i_machine_idle     (i_machine_idle),
        .o_strobe           (o_strobe),
        .o_woken_valid      (o_woken_valid),
        .o_woken_thread     (o_woken_thread),
        .o_yield_request    (o_yield_request),
        .o_request_rejected (o_request_rejected),
        .o_last             (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string fname, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %0h want %0h", fname, got, want));
    endtask

    task automatic push_wake(input logic vld, input logic [7:0] id, input logic yld,
                             input logic rej, input logic lst);
        t_wake_result r;
        r.woken_valid      = vld;
        r.woken_thread     = id;
        r.yield_request    = yld;
        r.request_rejected = rej;
        r.last             = lst;
        wake_q.push_back(r);
    endtask

    // Works out the results of one accepted word and updates the table copy.
    task automatic predict_wakes(input logic op, input logic [7:0] tid,
                                 input logic [15:0] tks, input logic idle);
        logic [ID_W-1:0] woken[$];
        int wr;
        woken = {};
        wr = 0;
        if (op == OP_SLEEP) begin
            if (sleepers >= MAX_SLEEPERS) begin
                push_wake(1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
            end else begin
                for (int i = sleepers; i > 0; i--) begin
                    sleep_left[i]  = sleep_left[i-1];
                    sleep_owner[i] = sleep_owner[i-1];
                end
                sleep_left[0]  = {1'b0, tks[TICK_WIDTH-1:0]};
                sleep_owner[0] = tid;
                sleepers++;
                push_wake(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
            end
        end else begin
            for (int rd = 0; rd < sleepers; rd++) begin
                if (sleep_left[rd] <= 1) begin
                    woken.push_back(sleep_owner[rd]);
                end else begin
                    sleep_left[wr]  = sleep_left[rd] - 1'b1;
                    sleep_owner[wr] = sleep_owner[rd];
                    wr++;
                end
            end
            sleepers = wr;
            if (woken.size() == 0) begin
                push_wake(1'b0, 8'h00, !idle, 1'b0, 1'b1);
            end else begin
                foreach (woken[k])
                    push_wake(1'b1, woken[k], (k == woken.size() - 1) ? !idle : 1'b0,
                              1'b0, k == woken.size() - 1);
            end
        end
    endtask

    // Called at a rising edge; returns at the edge where the word is taken.
    // start is left high so a back-to-back word needs no second assignment.
    task automatic send_word(input logic op, input logic [7:0] tid,
                             input logic [15:0] tks, input logic idle);
        start          <= 1'b1;
        i_opcode       <= op;
        i_thread_id    <= tid;
        i_ticks        <= tks;
        i_machine_idle <= idle;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        predict_wakes(op, tid, tks, idle);
    endtask

    // Random pause after a word: mostly none or short, now and then long.
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic sleep_gap(input logic [7:0] tid, input logic [15:0] tks);
        send_word(OP_SLEEP, tid, tks, 1'($urandom_range(0, 1)));
        idle_gap();
    endtask

    task automatic tick_gap(input logic idle);
        send_word(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  idle);
        idle_gap();
    endtask

    always @(posedge i_clk) begin
        t_wake_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (wake_q.size() == 0) begin
                log_mismatch("result with nothing expected");
            end else begin
                want = wake_q.pop_front();
                check_field("woken_valid", 8'(o_woken_valid), 8'(want.woken_valid));
                check_field("woken_thread", o_woken_thread, want.woken_thread);
                check_field("yield_request", 8'(o_yield_request),
                            8'(want.yield_request));
                check_field("request_rejected", 8'(o_request_rejected),
                            8'(want.request_rejected));
                check_field("last", 8'(o_last), 8'(want.last));
            end
        end
    end

    // empty table: a tick gives one bare result, yield follows machine_idle
    task automatic test_empty_ticks();
        tick_gap(1'b1);
        tick_gap(1'b0);
    endtask

    // zero and one tick both wake at the next tick, newest first
    task automatic test_short_sleeps();
        sleep_gap(8'hFF, 16'h0000);
        sleep_gap(8'h00, 16'h0001);
        sleep_gap(8'h5A, 16'hFFFF);
        tick_gap(1'b0);
    endtask

    // fill the table up to its last slot, then two ticks release the lot
    task automatic test_full_table();
        for (int i = 0; i < MAX_SLEEPERS - 1; i++)
            sleep_gap(8'h10 + i[7:0], 16'(i % 3));
        sleep_gap(8'hC3, 16'h0000);
        tick_gap(1'b1);
        tick_gap(1'b0);
    endtask

    function automatic logic [15:0] sleep_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 16'($urandom_range(0, 4));
        else if (r < 97)
            return 16'($urandom_range(5, 40));
        return 16'($urandom_range(0, 65535));
    endfunction

    // bursts of sleeps followed by ticks, mixed with stray single words
    task automatic test_random();
        int sent;
        int k;
        sent = 0;
        while (sent < 330) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(1, 18);
                repeat (k) sleep_gap(8'($urandom_range(0, 255)), sleep_length());
                sent += k;
                k = $urandom_range(1, 6);
                repeat (k) tick_gap(1'($urandom_range(0, 1)));
            end else if ($urandom_range(0, 1) == 1) begin
                sleep_gap(8'($urandom_range(0, 255)), sleep_length());
                k = 1;
            end else begin
                tick_gap(1'($urandom_range(0, 1)));
                k = 1;
            end
            sent = sent + k;
        end
        quiet_phase = 1'b0;
    endtask

    initial begin
        int waited;
        foreach (sleep_left[i]) begin
            sleep_left[i]  = '0;
            sleep_owner[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_ticks();
        test_short_sleeps();
        test_full_table();
        test_random();

        start <= 1'b0;
        waited = 0;
        while (wake_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        while (wake_q.size() != 0) begin
            void'(wake_q.pop_front());
            log_mismatch("expected result never came");
        end
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
